// ----- rtl/lpfp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpfp_pkg
// Types, codes and reset values shared by the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

	localparam int unsigned LEN_LIMIT_W   = 17;
	localparam int unsigned DIM_W         = 16;
	localparam int unsigned CFG_DATA_W    = 17;
	localparam int unsigned CFG_INDEX_W   = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_LEN_LIMIT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_COLS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_ROWS = 2'd2;

	localparam logic [LEN_LIMIT_W-1:0] LEN_LIMIT_RST    = 17'(64 * 1024);
	localparam logic [DIM_W-1:0]       DEFAULT_COLS_RST = 16'd80;
	localparam logic [DIM_W-1:0]       DEFAULT_ROWS_RST = 16'd24;

	localparam logic [7:0] TYPE_DATA   = 8'h01;
	localparam logic [7:0] TYPE_RESIZE = 8'h02;
	localparam logic [7:0] TYPE_HELLO  = 8'h04;

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_OPEN   = 2'd1;
	localparam logic [1:0] KIND_RESIZE = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	typedef struct packed {
		logic [LEN_LIMIT_W-1:0] len_limit;
		logic [DIM_W-1:0]       default_cols;
		logic [DIM_W-1:0]       default_rows;
	} lpfp_cfg_t;

endpackage

// ----- rtl/lpfp_byte_if.sv -----
// ----------------------------------------------------------------------------
// lpfp_byte_if
// Valid/ready channel carrying one stream byte per item.
// ----------------------------------------------------------------------------
interface lpfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

// ----- rtl/lpfp_event_if.sv -----
// ----------------------------------------------------------------------------
// lpfp_event_if
// Valid/ready channel carrying one parser result per item.
// ----------------------------------------------------------------------------
interface lpfp_event_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] cols;
	logic [15:0] rows;
	logic        frame_end;

	modport source (output valid, output kind, output data_byte, output cols,
		output rows, output frame_end, input ready);
	modport sink (input valid, input kind, input data_byte, input cols,
		input rows, input frame_end, output ready);
endinterface

// ----- rtl/lpfp_cfg.sv -----
// ----------------------------------------------------------------------------
// lpfp_cfg
// Configuration registers: maximum payload length and window defaults.
// ----------------------------------------------------------------------------
module lpfp_cfg
	import lpfp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output lpfp_cfg_t              cfg
);

	lpfp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.len_limit    <= LEN_LIMIT_RST;
			cfg_q.default_cols <= DEFAULT_COLS_RST;
			cfg_q.default_rows <= DEFAULT_ROWS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEN_LIMIT:    cfg_q.len_limit    <= cfg_data[LEN_LIMIT_W-1:0];
				REG_DEFAULT_COLS: cfg_q.default_cols <= cfg_data[DIM_W-1:0];
				REG_DEFAULT_ROWS: cfg_q.default_rows <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/lpfp_in_stage.sv -----
// ----------------------------------------------------------------------------
// lpfp_in_stage
// Input register: holds one accepted stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module lpfp_in_stage
	import lpfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	lpfp_byte_if.sink    byte_in,
	input  logic         take,
	output logic         vld_s1,
	output logic [7:0]   byte_s1
);

	logic vld_q;
	logic [7:0] byte_q;

	assign byte_in.ready = !vld_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (byte_in.ready) begin
			vld_q <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_q <= byte_in.stream_byte;
		end
	end

	assign vld_s1  = vld_q;
	assign byte_s1 = byte_q;

endmodule

// ----- rtl/lpfp_parser.sv -----
// ----------------------------------------------------------------------------
// lpfp_parser
// Frame state machine and result register: header, length, payload, error.
// ----------------------------------------------------------------------------
module lpfp_parser
	import lpfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  lpfp_cfg_t    cfg,
	input  logic         vld_s1,
	input  logic [7:0]   byte_s1,
	output logic         take,
	lpfp_event_if.source event_out
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_ERROR   = 2'd2;

	logic [1:0]             phase_q, phase_d;
	logic [2:0]             hcount_q, hcount_d;
	logic [7:0]             fkind_q, fkind_d;
	logic [31:0]            len_q, len_d;
	logic [LEN_LIMIT_W-1:0] left_q, left_d;
	logic [31:0]            size_q, size_d;
	logic [2:0]             pcount_q, pcount_d;
	logic                   open_q, open_d;

	logic        res_vld;
	logic [1:0]  res_kind;
	logic [7:0]  res_byte;
	logic [15:0] res_cols;
	logic [15:0] res_rows;
	logic        res_end;

	logic        out_vld_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [15:0] cols_q;
	logic [15:0] rows_q;
	logic        end_q;

	logic [31:0]            len_next;
	logic [LEN_LIMIT_W-1:0] left_next;
	logic                   fin;
	logic [31:0]            fin_size;
	logic [2:0]             fin_pcount;
	logic [15:0]            fin_cols;
	logic [15:0]            fin_rows;
	logic                   win_frame;

	assign take = vld_s1 && (!out_vld_q || event_out.ready);

	assign len_next  = {len_q[23:0], byte_s1};
	assign left_next = left_q - LEN_LIMIT_W'(1);
	assign win_frame = (fkind_q == TYPE_HELLO) || (fkind_q == TYPE_RESIZE);

	always_comb begin
		fin_cols = cfg.default_cols;
		fin_rows = cfg.default_rows;
		if (fin_pcount >= 3'd4) begin
			if (fin_size[31:16] != 16'd0) fin_cols = fin_size[31:16];
			if (fin_size[15:0] != 16'd0) fin_rows = fin_size[15:0];
		end
	end

	always_comb begin
		phase_d  = phase_q;
		hcount_d = hcount_q;
		fkind_d  = fkind_q;
		len_d    = len_q;
		left_d   = left_q;
		size_d   = size_q;
		pcount_d = pcount_q;
		open_d   = open_q;
		res_vld  = 1'b0;
		res_kind = KIND_DATA;
		res_byte = 8'd0;
		res_cols = 16'd0;
		res_rows = 16'd0;
		res_end  = 1'b0;
		fin        = 1'b0;
		fin_size   = 32'd0;
		fin_pcount = 3'd0;
		case (phase_q)
			PH_HEADER: begin
				if (hcount_q == 3'd0) begin
					fkind_d  = byte_s1;
					len_d    = 32'd0;
					hcount_d = 3'd1;
				end else if (hcount_q != 3'd4) begin
					len_d    = len_next;
					hcount_d = hcount_q + 3'd1;
				end else begin
					len_d    = len_next;
					hcount_d = 3'd0;
					if (len_next > {15'd0, cfg.len_limit}) begin
						phase_d  = PH_ERROR;
						res_vld  = 1'b1;
						res_kind = KIND_ERROR;
					end else begin
						left_d   = len_next[LEN_LIMIT_W-1:0];
						size_d   = 32'd0;
						pcount_d = 3'd0;
						if (len_next[LEN_LIMIT_W-1:0] == '0) fin = 1'b1;
						else phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				left_d = left_next;
				if (pcount_q < 3'd4) begin
					size_d   = {size_q[23:0], byte_s1};
					pcount_d = pcount_q + 3'd1;
				end
				fin_size   = size_d;
				fin_pcount = pcount_d;
				if (left_next == '0) phase_d = PH_HEADER;
				if (fkind_q == TYPE_DATA) begin
					res_vld  = 1'b1;
					res_byte = byte_s1;
					res_end  = (left_next == '0);
				end else if (left_next == '0) begin
					fin = 1'b1;
				end
			end
			default: ;
		endcase
		if (fin && win_frame) begin
			if (fkind_q == TYPE_HELLO && !open_q) begin
				open_d   = 1'b1;
				res_vld  = 1'b1;
				res_kind = KIND_OPEN;
				res_cols = fin_cols;
				res_rows = fin_rows;
			end else if (open_q) begin
				res_vld  = 1'b1;
				res_kind = KIND_RESIZE;
				res_cols = fin_cols;
				res_rows = fin_rows;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hcount_q <= 3'd0;
			fkind_q  <= 8'd0;
			len_q    <= 32'd0;
			left_q   <= '0;
			size_q   <= 32'd0;
			pcount_q <= 3'd0;
			open_q   <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			hcount_q <= hcount_d;
			fkind_q  <= fkind_d;
			len_q    <= len_d;
			left_q   <= left_d;
			size_q   <= size_d;
			pcount_q <= pcount_d;
			open_q   <= open_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take && res_vld) begin
			out_vld_q <= 1'b1;
		end else if (event_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_vld) begin
			kind_q <= res_kind;
			byte_q <= res_byte;
			cols_q <= res_cols;
			rows_q <= res_rows;
			end_q  <= res_end;
		end
	end

	assign event_out.valid     = out_vld_q;
	assign event_out.kind      = kind_q;
	assign event_out.data_byte = byte_q;
	assign event_out.cols      = cols_q;
	assign event_out.rows      = rows_q;
	assign event_out.frame_end = end_q;

endmodule

// ----- rtl/length_prefixed_frame_parser_unit.sv -----
// A byte passes the input register and then the parse step into the result register.
// Throughput: one byte per cycle while no result waits, set by the single parse step
// between the input register and the result register; while a result waits, the
// input register takes one more byte and then stalls. Reset clears the parse state,
// the session flag and both valids, and loads the register defaults (65536, 80, 24).
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_unit
// Parses type/length/payload frames into data bytes, window events and length errors.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_unit
	import lpfp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	lpfp_byte_if.sink              byte_in,
	lpfp_event_if.source           event_out
);

	lpfp_cfg_t  cfg;
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       take;

	lpfp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lpfp_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.take    (take),
		.vld_s1  (vld_s1),
		.byte_s1 (byte_s1)
	);

	lpfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.vld_s1    (vld_s1),
		.byte_s1   (byte_s1),
		.take      (take),
		.event_out (event_out)
	);

endmodule
